@@ hdl/clnws_pkg.sv @@
// Shared types, request codes and timing constants for the character LCD
// nibble write sequencer. No dependencies; every other file imports this package.
package clnws_pkg;

  // Request kinds carried on the kind input.
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;
  localparam logic [1:0] KIND_INIT   = 2'd3;

  // Display address constants.
  localparam logic [7:0] LINE0_BASE   = 8'h80;
  localparam logic [7:0] LINE1_OFFSET = 8'h40;

  // Init command bytes.
  localparam logic [7:0] INIT_CMD_WAKE = 8'h03;
  localparam logic [7:0] INIT_CMD_4BIT = 8'h02;

  // Phase hold times in microseconds.
  localparam int HOLD_W = 19;
  localparam logic [HOLD_W-1:0] PULSE_US   = 19'd5;
  localparam logic [HOLD_W-1:0] SETTLE_US  = 19'd50;
  localparam logic [HOLD_W-1:0] POWERUP_US = 19'd500000;
  localparam logic [HOLD_W-1:0] EXTRA_5MS  = 19'd5000;
  localparam logic [HOLD_W-1:0] EXTRA_500  = 19'd500;

  // Position of a phase within a run: sub is the phase inside one byte write.
  localparam logic [2:0] SUB_FINAL  = 3'd4;
  localparam logic [1:0] CMD_FINAL  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_val;
  } req_t;

  typedef struct packed {
    logic       opening;  // power-up phase of an init run
    logic [1:0] cmd;      // init command index
    logic [2:0] sub;      // phase inside one byte write
  } phase_pos_t;

  typedef struct packed {
    logic              reg_select;
    logic              enable_pin;
    logic [7:0]        port_value;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } phase_t;

  // Cursor address: line base plus column, wrapped to eight bits.
  function automatic logic [7:0] cursor_addr(input logic row, input logic [7:0] column);
    logic [7:0] base;
    base = row ? (LINE0_BASE + LINE1_OFFSET) : LINE0_BASE;
    return base + column;
  endfunction

endpackage

@@ hdl/clnws_phase_gen.sv @@
// Combinational mapping from a held request and a phase position to the pin
// levels and hold time of that phase. Depends on clnws_pkg.
module clnws_phase_gen (
  input  clnws_pkg::req_t       req,
  input  clnws_pkg::phase_pos_t pos,
  output clnws_pkg::phase_t     phase
);
  import clnws_pkg::*;

  logic              is_init;
  logic [7:0]        byte_sel;
  logic [HOLD_W-1:0] extra;

  assign is_init = (req.kind == KIND_INIT);

  // Init sends wake-up commands, then the 4-bit mode command.
  always_comb begin
    if (is_init) begin
      byte_sel = (pos.cmd == CMD_FINAL) ? INIT_CMD_4BIT : INIT_CMD_WAKE;
    end else begin
      byte_sel = req.byte_val;
    end
  end

  // Extra settle time after each init wake-up command.
  always_comb begin
    case (pos.cmd)
      2'd0:    extra = EXTRA_5MS;
      2'd1:    extra = EXTRA_500;
      2'd2:    extra = EXTRA_500;
      default: extra = '0;
    endcase
    if (!is_init) begin
      extra = '0;
    end
  end

  // Phase fields: high nibble on the first two phases, low nibble after.
  always_comb begin
    if (pos.opening) begin
      phase.reg_select = 1'b0;
      phase.enable_pin = 1'b0;
      phase.port_value = '0;
      phase.hold_us    = POWERUP_US;
      phase.last       = 1'b0;
    end else begin
      phase.reg_select = (req.kind == KIND_DATA);
      phase.enable_pin = pos.sub[0];
      phase.port_value = (pos.sub < 3'd2) ? byte_sel : {byte_sel[3:0], 4'h0};
      phase.hold_us    = (pos.sub == SUB_FINAL) ? (SETTLE_US + extra) : PULSE_US;
      phase.last       = (pos.sub == SUB_FINAL) && (!is_init || pos.cmd == CMD_FINAL);
    end
  end

endmodule

@@ hdl/clnws_out_stage.sv @@
// Output register for the phase words, with valid and ready toward the sink.
// Depends on clnws_pkg.
module clnws_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  clnws_pkg::phase_t load_phase,
  input  logic              load_driven,
  output logic              out_valid,
  input  logic              out_ready,
  output clnws_pkg::phase_t out_phase,
  output logic              out_driven
);
  import clnws_pkg::*;

  // The register takes a new word when empty or when its word leaves now.
  assign load_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      out_phase  <= load_phase;
      out_driven <= load_driven;
    end
  end

endmodule

@@ hdl/char_lcd_nibble_write_sequencer.sv @@
// Top level of the character LCD nibble write sequencer: request register,
// phase counter and pins-driven flag. Uses clnws_pkg, clnws_phase_gen, clnws_out_stage.
//
// Each accepted request becomes a run of pin phase words, one word per cycle
// while the sink is ready. Command, data and cursor requests give 5 words; an
// init request gives 21 (a 500 ms all-low phase, then four command writes).
// The phase counter held with the request sets the pace; the next request is
// taken in the cycle its predecessor's final word moves to the output register.
// The final word of each run has last set. driven reads high from the first
// init onward.
module char_lcd_nibble_write_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    value,
  input  logic                          row,
  input  logic [7:0]                    column,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          reg_select,
  output logic                          enable_pin,
  output logic [7:0]                    port_value,
  output logic [clnws_pkg::HOLD_W-1:0]  hold_us,
  output logic                          driven,
  output logic                          last
);
  import clnws_pkg::*;

  logic       req_valid;
  req_t       req;
  req_t       req_next;
  phase_pos_t pos;
  logic       pins_enabled;
  phase_t     phase;
  phase_t     out_phase;
  logic       stage_ready;
  logic       advance;
  logic       in_take;

  // A phase word moves out when the output register can take it.
  assign advance  = req_valid && stage_ready;
  assign in_ready = !req_valid || (advance && phase.last);
  assign in_take  = in_valid && in_ready;

  // Byte to write is fixed at acceptance.
  always_comb begin
    req_next.kind = kind;
    if (kind == KIND_CURSOR) begin
      req_next.byte_val = cursor_addr(row, column);
    end else begin
      req_next.byte_val = value;
    end
  end

  // Request register and phase position.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid   <= 1'b0;
      pos         <= '0;
    end else if (in_take) begin
      req_valid   <= 1'b1;
      pos.opening <= (kind == KIND_INIT);
      pos.cmd     <= '0;
      pos.sub     <= '0;
    end else if (advance) begin
      if (phase.last) begin
        req_valid <= 1'b0;
      end else if (pos.opening) begin
        pos.opening <= 1'b0;
      end else if (pos.sub == SUB_FINAL) begin
        pos.sub <= '0;
        pos.cmd <= pos.cmd + 2'd1;
      end else begin
        pos.sub <= pos.sub + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req <= req_next;
    end
  end

  // Pins count as driven from the first init request on.
  always_ff @(posedge clk) begin
    if (rst) begin
      pins_enabled <= 1'b0;
    end else if (in_take && kind == KIND_INIT) begin
      pins_enabled <= 1'b1;
    end
  end

  clnws_phase_gen u_phase_gen (
    .req   (req),
    .pos   (pos),
    .phase (phase)
  );

  clnws_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (req_valid),
    .load_ready  (stage_ready),
    .load_phase  (phase),
    .load_driven (pins_enabled),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_phase   (out_phase),
    .out_driven  (driven)
  );

  assign reg_select = out_phase.reg_select;
  assign enable_pin = out_phase.enable_pin;
  assign port_value = out_phase.port_value;
  assign hold_us    = out_phase.hold_us;
  assign last       = out_phase.last;

endmodule
